// ===== hw/rtl/psm_pkg.sv =====
// Shared types and constants for the packet slice matcher.
// Used by psm_window and packet_slice_matcher.
`timescale 1ns / 1ps
`default_nettype none
package psm_pkg;

  localparam int MAX_PATTERN   = 8;
  localparam int POSITION_BITS = 16;

  localparam int CNT_W         = 16;
  localparam int SLICE_W       = 16;
  localparam int PAT_BYTES_W   = 64;
  localparam int PAT_LEN_W     = 4;
  localparam int MODE_W        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam int PAT_STORED    = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int PAT_IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PLEN_W        = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W         = (POSITION_BITS > SLICE_W) ? POSITION_BITS : SLICE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_EQUALS     = 2'd0,
    MODE_NOT_EQUALS = 2'd1,
    MODE_CONTAINS   = 2'd2
  } psm_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_START    = 3'd0,
    CFG_SLICE_LENGTH   = 3'd1,
    CFG_COMPARE_MODE   = 3'd2,
    CFG_PATTERN_BYTES  = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4
  } psm_cfg_idx_e;

  typedef struct packed {
    logic [SLICE_W-1:0]     slice_start;
    logic [SLICE_W-1:0]     slice_length;
    logic [MODE_W-1:0]      compare_mode;
    logic [PAT_BYTES_W-1:0] pattern_bytes;
    logic [PAT_LEN_W-1:0]   pattern_length;
  } psm_cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/psm_in_if.sv =====
// Byte stream channel into the packet slice matcher.
// Carries valid, ready, data_byte and frame_end; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface psm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/psm_out_if.sv =====
// Verdict channel out of the packet slice matcher.
// Carries valid, ready and matched; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface psm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/packet_slice_matcher.sv =====
// Top level of the packet slice matcher: configuration registers, input
// register, verdict register. Depends on psm_pkg, psm_in_if, psm_out_if, psm_window.
// The last byte of a frame passes through the input register into the verdict register.
// Throughput: one byte per cycle while the verdict channel is ready.
// Input register and verdict register hold one entry each; a stalled verdict
// stalls the input only once the input register is also full.
// Reset clears configuration to zero and all frame state to its start value.
`timescale 1ns / 1ps
`default_nettype none
module packet_slice_matcher (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  psm_in_if.sink                              in_if,
  psm_out_if.source                           out_if,
  input  wire logic                           cfg_we_i,
  input  wire logic [psm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [psm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  psm_pkg::psm_cfg_t cfg_q;
  logic              in_valid_q;
  logic [7:0]        data_byte_q;
  logic              frame_end_q;
  logic              out_valid_q;
  logic              matched_q;
  logic              adv;
  logic              matched;

  assign adv          = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !in_valid_q || adv;
  assign out_if.valid = out_valid_q;
  assign out_if.matched = matched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (psm_pkg::psm_cfg_idx_e'(cfg_idx_i))
        psm_pkg::CFG_SLICE_START:    cfg_q.slice_start    <= cfg_wdata_i[15:0];
        psm_pkg::CFG_SLICE_LENGTH:   cfg_q.slice_length   <= cfg_wdata_i[15:0];
        psm_pkg::CFG_COMPARE_MODE:   cfg_q.compare_mode   <= cfg_wdata_i[1:0];
        psm_pkg::CFG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= cfg_wdata_i;
        psm_pkg::CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      data_byte_q <= in_if.data_byte;
      frame_end_q <= in_if.frame_end;
    end
  end

  psm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .adv_i       (adv),
    .data_byte_i (data_byte_q),
    .frame_end_i (frame_end_q),
    .matched_o   (matched)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && frame_end_q) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && frame_end_q) begin
      matched_q <= matched;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> in_valid_q && out_valid_q && !out_if.ready)
    else $error("input stalled while a stage is free");

  a_verdict_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && frame_end_q))
    else $error("verdict raised without a last byte");

  a_cfg_start_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == psm_pkg::CFG_SLICE_START)
    |=> cfg_q.slice_start == $past(cfg_wdata_i[15:0]))
    else $error("slice start write lost");

endmodule
`default_nettype wire

// ===== hw/rtl/psm_window.sv =====
// Per-frame window state and compare logic of the packet slice matcher.
// Depends on psm_pkg for widths, mode codes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none
module psm_window (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire psm_pkg::psm_cfg_t cfg_i,
  input  wire logic            adv_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            frame_end_i,
  output logic                 matched_o
);

  logic [psm_pkg::POSITION_BITS-1:0] pos_q, pos_d;
  logic [psm_pkg::CNT_W-1:0]         cnt_q, cnt_d, cnt_upd;
  logic                              eq_q, eq_d, eq_upd;
  logic                              found_q, found_d, found_upd;
  logic [7:0]                        hist_q   [psm_pkg::MAX_PATTERN];
  logic [7:0]                        hist_d   [psm_pkg::MAX_PATTERN];
  logic [7:0]                        hist_upd [psm_pkg::MAX_PATTERN];
  logic [7:0]                        pat      [psm_pkg::MAX_PATTERN];
  logic [psm_pkg::MAX_PATTERN-1:0]   hit_by_len;
  logic [psm_pkg::PLEN_W-1:0]        plen;
  logic [psm_pkg::PAT_IDX_W-1:0]     plen_m1;
  logic                              in_slice, in_win, eq_now;

  always_comb begin
    for (int i = 0; i < psm_pkg::MAX_PATTERN; i++) begin
      pat[i] = '0;
    end
    for (int i = 0; i < psm_pkg::PAT_STORED; i++) begin
      pat[i] = cfg_i.pattern_bytes[8*i +: 8];
    end
  end

  always_comb begin
    plen = ({1'b0, cfg_i.pattern_length} > 5'(psm_pkg::MAX_PATTERN))
         ? psm_pkg::PLEN_W'(psm_pkg::MAX_PATTERN)
         : psm_pkg::PLEN_W'(cfg_i.pattern_length);
    plen_m1  = psm_pkg::PAT_IDX_W'(plen - 1'b1);
    in_slice = psm_pkg::CMP_W'(pos_q) >= psm_pkg::CMP_W'(cfg_i.slice_start);
    in_win   = in_slice && (cnt_q < cfg_i.slice_length);

    hist_upd  = hist_q;
    cnt_upd   = cnt_q;
    eq_upd    = eq_q;
    found_upd = found_q;
    if (in_win) begin
      if ((cnt_q < psm_pkg::CNT_W'(plen)) &&
          (data_byte_i != pat[cnt_q[psm_pkg::PAT_IDX_W-1:0]])) begin
        eq_upd = 1'b0;
      end
      hist_upd[0] = data_byte_i;
      for (int i = 1; i < psm_pkg::MAX_PATTERN; i++) begin
        hist_upd[i] = hist_q[i-1];
      end
      if (cnt_q != '1) begin
        cnt_upd = cnt_q + 1'b1;
      end
    end

    for (int l = 0; l < psm_pkg::MAX_PATTERN; l++) begin
      hit_by_len[l] = 1'b1;
      for (int j = 0; j <= l; j++) begin
        if (hist_upd[l-j] != pat[j]) begin
          hit_by_len[l] = 1'b0;
        end
      end
    end
    if (in_win && (plen != '0) && (cnt_upd >= psm_pkg::CNT_W'(plen)) &&
        hit_by_len[plen_m1]) begin
      found_upd = 1'b1;
    end

    eq_now = (cnt_upd == psm_pkg::CNT_W'(plen)) && eq_upd;
    case (psm_pkg::psm_mode_e'(cfg_i.compare_mode))
      psm_pkg::MODE_EQUALS:     matched_o = in_slice && eq_now;
      psm_pkg::MODE_NOT_EQUALS: matched_o = in_slice && !eq_now;
      psm_pkg::MODE_CONTAINS:   matched_o = in_slice && found_upd;
      default:                  matched_o = 1'b0;
    endcase

    pos_d = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
    if (frame_end_i) begin
      pos_d   = '0;
      cnt_d   = '0;
      eq_d    = 1'b1;
      found_d = 1'b0;
      for (int i = 0; i < psm_pkg::MAX_PATTERN; i++) begin
        hist_d[i] = '0;
      end
    end else begin
      cnt_d   = cnt_upd;
      eq_d    = eq_upd;
      found_d = found_upd;
      hist_d  = hist_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      cnt_q   <= '0;
      eq_q    <= 1'b1;
      found_q <= 1'b0;
      for (int i = 0; i < psm_pkg::MAX_PATTERN; i++) begin
        hist_q[i] <= '0;
      end
    end else if (adv_i) begin
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      eq_q    <= eq_d;
      found_q <= found_d;
      hist_q  <= hist_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && frame_end_i |=> (pos_q == '0) && (cnt_q == '0) && eq_q && !found_q)
    else $error("frame state not cleared after last byte");

  a_mismatch_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !eq_q |-> (cnt_q != '0))
    else $error("mismatch recorded with empty window");

endmodule
`default_nettype wire

// ===== test/packet_slice_matcher_checker.sv =====
// Checker for the packet slice matcher: watches both streams and the register port,
// predicts one verdict per frame and compares it with the transferred verdicts.
// Depends on psm_pkg, psm_in_if and psm_out_if.
`timescale 1ns / 1ps
module packet_slice_matcher_checker
  import psm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  psm_in_if                     in_mon,
  psm_out_if                    out_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatch_count_o,
  output int                    pending_verdicts_o
);

  localparam logic [POSITION_BITS-1:0] POS_TOP = '1;

  psm_cfg_t                 cfg;
  logic [POSITION_BITS-1:0] byte_pos;
  logic [7:0]               history [MAX_PATTERN];
  logic [CNT_W-1:0]         window_cnt;
  logic                     equal_so_far;
  logic                     pattern_seen;
  logic                     awaited_verdicts [$];
  logic                     expected;

  function automatic logic [7:0] pattern_byte(int unsigned i);
    if (i >= 8) return 8'h00;
    return cfg.pattern_bytes[8*i +: 8];
  endfunction

  function automatic void clear_frame();
    int unsigned j;
    byte_pos = '0;
    for (j = 0; j < MAX_PATTERN; j++) history[j] = 8'h00;
    window_cnt = '0;
    equal_so_far = 1'b1;
    pattern_seen = 1'b0;
  endfunction

  function automatic void report(string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    int unsigned              plen;
    int unsigned              j;
    logic [POSITION_BITS-1:0] pos;
    logic                     hit;
    logic                     in_window;
    logic                     eq;
    logic                     verdict;
    plen = (cfg.pattern_length > MAX_PATTERN) ? MAX_PATTERN : cfg.pattern_length;
    pos = byte_pos;
    if (pos >= cfg.slice_start && window_cnt < cfg.slice_length) begin
      if (window_cnt < plen && b != pattern_byte(window_cnt)) equal_so_far = 1'b0;
      for (j = MAX_PATTERN - 1; j > 0; j--) history[j] = history[j-1];
      history[0] = b;
      if (window_cnt != '1) window_cnt++;
      if (plen > 0 && window_cnt >= plen) begin
        hit = 1'b1;
        for (j = 0; j < plen; j++) begin
          if (history[plen-1-j] != pattern_byte(j)) hit = 1'b0;
        end
        if (hit) pattern_seen = 1'b1;
      end
    end
    if (pos != POS_TOP) byte_pos = pos + 1'b1;
    if (last) begin
      in_window = pos >= cfg.slice_start;
      eq = (window_cnt == plen) && equal_so_far;
      case (cfg.compare_mode)
        MODE_EQUALS:     verdict = in_window && eq;
        MODE_NOT_EQUALS: verdict = in_window && !eq;
        MODE_CONTAINS:   verdict = in_window && pattern_seen;
        default:         verdict = 1'b0;
      endcase
      awaited_verdicts = {awaited_verdicts, verdict};
      clear_frame();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '0;
      clear_frame();
      awaited_verdicts.delete();
      mismatch_count_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_verdicts.size() == 0) begin
          report($sformatf("unexpected verdict, got matched=%0b", out_mon.matched));
        end else begin
          expected = awaited_verdicts.pop_front();
          if (out_mon.matched !== expected)
            report($sformatf("verdict mismatch, expected matched=%0b, got %0b",
                             expected, out_mon.matched));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLICE_START:    cfg.slice_start    = cfg_wdata_i[SLICE_W-1:0];
          CFG_SLICE_LENGTH:   cfg.slice_length   = cfg_wdata_i[SLICE_W-1:0];
          CFG_COMPARE_MODE:   cfg.compare_mode   = cfg_wdata_i[MODE_W-1:0];
          CFG_PATTERN_BYTES:  cfg.pattern_bytes  = cfg_wdata_i[PAT_BYTES_W-1:0];
          CFG_PATTERN_LENGTH: cfg.pattern_length = cfg_wdata_i[PAT_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.data_byte, in_mon.frame_end);
    end
    pending_verdicts_o = awaited_verdicts.size();
  end

endmodule

// ===== test/packet_slice_matcher_tb.sv =====
// Testbench top for the packet slice matcher: clock, reset, register writes,
// byte stimulus and verdict back-pressure, then the final verdict.
// Depends on psm_pkg, psm_in_if, psm_out_if and packet_slice_matcher_checker.
`timescale 1ns / 1ps
module packet_slice_matcher_tb;
  import psm_pkg::*;

  localparam int              IDLE_LIMIT  = 5000;
  localparam int              PHASE_ITEMS = 488;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    pending_verdicts;
  int                    idle_pct;
  int                    stall_pct;
  int                    stuck_cycles;

  psm_in_if  in_ch ();
  psm_out_if out_ch ();

  packet_slice_matcher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  packet_slice_matcher_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_mon             (in_ch),
    .out_mon            (out_ch),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .mismatch_count_o   (mismatches),
    .pending_verdicts_o (pending_verdicts)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= IDLE_LIMIT) begin
      $display("packet_slice_matcher regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [SLICE_W-1:0] start, input logic [SLICE_W-1:0] len,
                              input logic [MODE_W-1:0] mode, input logic [63:0] pat,
                              input logic [PAT_LEN_W-1:0] plen);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_SLICE_START, {junk[63:SLICE_W], start});
    write_reg(CFG_SLICE_LENGTH, {junk[63:SLICE_W], len});
    write_reg(CFG_COMPARE_MODE, {junk[63:MODE_W], mode});
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_PATTERN_LENGTH, {junk[63:PAT_LEN_W], plen});
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_end <= last;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] frame_q[$]);
    int i;
    for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // hold the input until every verdict is out and the pipeline is empty
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_verdicts != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic run_batch(output int sent);
    logic [7:0]        base [$];
    logic [7:0]        frm [$];
    logic [63:0]       pat;
    logic [MODE_W-1:0] mode;
    int                flen, st, wlen, clip, plen, off, nfrm, i, k, f;
    sent = 0;
    flen = ($urandom_range(9) == 0) ? $urandom_range(64, 21) : $urandom_range(20, 1);
    base.delete();
    for (i = 0; i < flen; i++)
      base = {base, ($urandom_range(1) ? 8'($urandom) : 8'h5A + 8'($urandom_range(3)))};
    case ($urandom_range(9))
      0:       st = 0;
      1:       st = $urandom_range(flen + 3, flen);
      2:       st = $urandom_range(65535);
      default: st = $urandom_range(flen - 1);
    endcase
    case ($urandom_range(9))
      0:       wlen = 0;
      1:       wlen = 65535;
      2:       wlen = $urandom_range(65535);
      default: wlen = $urandom_range(10);
    endcase
    mode = ($urandom_range(19) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(MODE_CONTAINS));
    clip = (st < flen) ? flen - st : 0;
    if (wlen < clip) clip = wlen;
    case ($urandom_range(9))
      0:       plen = $urandom_range(15, 9);
      1, 2:    plen = (clip > 8) ? 8 : clip;
      default: plen = $urandom_range(8);
    endcase
    pat = {$urandom, $urandom};
    if ($urandom_range(2) != 0 && clip > 0) begin
      off = (mode == MODE_CONTAINS) ? $urandom_range(clip - 1) : 0;
      for (k = 0; k < 8; k++)
        if (st + off + k < flen) pat[8*k +: 8] = base[st + off + k];
    end
    wait_drained();
    program_regs(st[SLICE_W-1:0], wlen[SLICE_W-1:0], mode, pat, plen[PAT_LEN_W-1:0]);
    nfrm = $urandom_range(6, 2);
    for (f = 0; f < nfrm; f++) begin
      frm = base;
      case ($urandom_range(3))
        1: begin
          k = $urandom_range(flen - 1);
          frm[k] = frm[k] ^ (8'h01 << $urandom_range(7));
        end
        2: begin
          frm.delete();
          repeat ($urandom_range(20, 1)) frm = {frm, 8'($urandom)};
        end
        3: while (frm.size() > 1 && $urandom_range(1) != 0) void'(frm.pop_back());
        default: ;
      endcase
      send_frame(frm);
      sent += frm.size();
    end
  endtask

  initial begin
    logic [7:0] frm [$];
    int         idle_pcts [4];
    int         stall_pcts [4];
    int         ph, phase_items, n, i;
    idle_pcts  = '{0, 81, 0, 21};
    stall_pcts = '{0, 0, 81, 21};
    idle_pct  = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.frame_end = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset: empty window, empty pattern
    frm = {8'h00};
    send_frame(frm);

    wait_drained();
    for (i = CFG_PATTERN_LENGTH + 1; i < (1 << CFG_IDX_W); i++) write_reg(CFG_IDX_W'(i), '1);
    program_regs(16'd1, 16'd3, MODE_EQUALS, 64'hFF807F, 4'd3);
    frm = {8'h00, 8'h7F, 8'h80, 8'hFF};
    send_frame(frm);

    // window clipped at the frame end
    wait_drained();
    program_regs(16'd1, 16'd3, MODE_NOT_EQUALS, 64'hFF807F, 4'd3);
    frm = {8'hFF, 8'h7F, 8'h80};
    send_frame(frm);

    // window starting past the frame end
    wait_drained();
    program_regs(16'd4, 16'd2, MODE_NOT_EQUALS, '1, 4'd2);
    frm = {8'h7F, 8'h80, 8'hFF};
    send_frame(frm);

    wait_drained();
    program_regs(16'd0, 16'd2, MODE_UNUSED, 64'h0, 4'd0);
    frm = {8'hFF};
    send_frame(frm);

    // pattern length above the stored byte count, full window length
    wait_drained();
    program_regs(16'd0, 16'hFFFF, MODE_CONTAINS, 64'h0807060504030201, 4'd15);
    frm = {8'h55, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08};
    send_frame(frm);

    // register change in the middle of a frame
    wait_drained();
    program_regs(16'd0, 16'd2, MODE_EQUALS, 64'hBBAA, 4'd2);
    send_byte(8'hAA, 1'b0);
    wait_drained();
    write_reg(CFG_PATTERN_BYTES, 64'hCCAA);
    cfg_we <= 1'b0;
    send_byte(8'hCC, 1'b1);

    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_pcts[ph];
      stall_pct = stall_pcts[ph];
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        run_batch(n);
        phase_items += n;
      end
    end

    wait_drained();
    if (mismatches == 0 && pending_verdicts == 0) begin
      $display("packet_slice_matcher regression: pass");
    end else begin
      $display("packet_slice_matcher regression: fail");
    end
    $finish;
  end

endmodule
